>>> rtl/core/frb_pkg.sv
// Package for the frame reorder buffer: sizes, command and status codes,
// and the bit layout of the stream payloads. No dependencies.
`default_nettype none

package frb_pkg;

    localparam int DEPTH = 16;
    localparam int TAG_W = 32;
    localparam int PTS_W = 64;
    localparam int IN_TAG_W = 32;
    localparam int OUT_TAG_W = 32;
    localparam int FILL_W = 5;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENTRY_W = PTS_W + TAG_W;

    localparam int CMD_W = 2;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic signed [PTS_W-1:0] PTS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    // slave payload: entry_pts, entry_tag; tuser: cmd
    localparam int S_PTS_LSB = 0;
    localparam int S_TAG_LSB = S_PTS_LSB + PTS_W;
    localparam int S_DATA_W = ((S_TAG_LSB + IN_TAG_W + 7) / 8) * 8;
    localparam int S_USER_W = CMD_W;

    // master payload: out_pts, out_tag, fill_count, next_pts; tuser: status, out_valid
    localparam int M_OPTS_LSB = 0;
    localparam int M_OTAG_LSB = M_OPTS_LSB + PTS_W;
    localparam int M_FILL_LSB = M_OTAG_LSB + OUT_TAG_W;
    localparam int M_NEXT_LSB = M_FILL_LSB + FILL_W;
    localparam int M_USED_W = M_NEXT_LSB + PTS_W;
    localparam int M_DATA_W = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W = M_DATA_W - M_USED_W;
    localparam int M_STATUS_LSB = 0;
    localparam int M_OVALID_BIT = STATUS_W;
    localparam int M_USER_W = STATUS_W + 1;

endpackage

`default_nettype wire

>>> rtl/core/frb_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module frb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/frame_reorder_buffer.sv
// Frame reorder buffer top level: sorted entry store in one RAM and the
// sequencer that walks it. Depends on frb_pkg and frb_ram.
//
// Commands arrive on the s_* stream (s_tuser = command, s_tdata = timestamp
// and tag); each gives exactly one result on the m_* stream (m_tuser = status
// and extract flag, m_tdata = extracted entry, fill count, next timestamp).
// Entries are kept sorted by signed timestamp; equal timestamps leave in
// arrival order.
// Steps per command: an insert into a non-empty buffer walks down from the
//   tail, moving each larger entry (0..DEPTH-1 of them) up one slot, then writes the new entry;
//   an extract reads the head and the whole tail shifts down one slot;
//   flush, error and unused codes go straight to the result.
// One entry moves per cycle through the RAM's single write port. The
// sequencer accepts the next command in the cycle after a result is loaded,
// even while that result still waits.
// If m_tready stays low the finished result holds in the output register
// and the sequencer waits before loading the next one.
// Reset empties the buffer (fill count 0) and drops any pending result;
// RAM contents are not cleared, stale entries are never read.
`default_nettype none

module frame_reorder_buffer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [63:0] entry_pts, [95:64] entry_tag
    input  wire logic [frb_pkg::S_DATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  wire logic [frb_pkg::S_USER_W-1:0]  s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [63:0] out_pts, [95:64] out_tag, [100:96] fill_count, [164:101] next_pts
    output logic      [frb_pkg::M_DATA_W-1:0]  m_tdata,
    // [1:0] status, [2] out_valid
    output logic      [frb_pkg::M_USER_W-1:0]  m_tuser
);

    import frb_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_INS_WALK = 5'b00010,
        ST_INS_LAST = 5'b00100,
        ST_EXT      = 5'b01000,
        ST_DONE     = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          ptr_reg, ptr_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [PTS_W-1:0]   head_reg, head_next;
    logic signed [PTS_W-1:0]   pts_reg, pts_next;
    logic [TAG_W-1:0]          tag_reg, tag_next;

    logic [STATUS_W-1:0]       res_status_reg, res_status_next;
    logic                      res_ovalid_reg, res_ovalid_next;
    logic signed [PTS_W-1:0]   res_opts_reg, res_opts_next;
    logic [OUT_TAG_W-1:0]      res_otag_reg, res_otag_next;

    logic                      m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]       m_data_reg, m_data_next;
    logic [M_USER_W-1:0]       m_user_reg, m_user_next;
    logic                      m_load;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [ENTRY_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]          ram_raddr;
    logic [ENTRY_W-1:0]        ram_rdata;

    logic [CMD_W-1:0]          in_cmd;
    logic signed [PTS_W-1:0]   in_pts;
    logic [IN_TAG_W-1:0]       in_tag;
    logic signed [PTS_W-1:0]   rd_pts;
    logic signed [PTS_W-1:0]   next_pts;

    assign in_cmd = s_tuser[CMD_W-1:0];
    assign in_pts = $signed(s_tdata[S_PTS_LSB +: PTS_W]);
    assign in_tag = s_tdata[S_TAG_LSB +: IN_TAG_W];
    assign rd_pts = $signed(ram_rdata[PTS_W-1:0]);
    assign next_pts = (count_reg != '0) ? head_reg : PTS_MAX;

    frb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        pts_next        = pts_reg;
        tag_next        = tag_reg;
        res_status_next = res_status_reg;
        res_ovalid_next = res_ovalid_reg;
        res_opts_next   = res_opts_reg;
        res_otag_next   = res_otag_reg;
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = ptr_reg;
        m_load          = 1'b0;
        s_tready        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    pts_next        = in_pts;
                    tag_next        = TAG_W'(in_tag);
                    res_status_next = STATUS_OK;
                    res_ovalid_next = 1'b0;
                    res_opts_next   = '0;
                    res_otag_next   = '0;
                    state_next      = ST_DONE;
                    unique case (in_cmd)
                        CMD_INSERT:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                                if (count_reg == '0 || in_pts < head_reg)
                                begin
                                    head_next = in_pts;
                                end
                                if (count_reg == '0)
                                begin
                                    state_next = ST_INS_LAST;
                                end
                                else
                                begin
                                    // walk down from the tail
                                    ptr_next   = IDX_W'(count_reg - CNT_W'(1));
                                    ram_raddr  = IDX_W'(count_reg - CNT_W'(1));
                                    state_next = ST_INS_WALK;
                                end
                            end
                        end
                        CMD_EXTRACT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next      = count_reg - CNT_W'(1);
                                res_ovalid_next = 1'b1;
                                res_opts_next   = head_reg;
                                ptr_next        = '0;
                                ram_raddr       = '0;
                                state_next      = ST_EXT;
                            end
                        end
                        CMD_FLUSH:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            // unused code: buffer left unchanged
                        end
                    endcase
                end
            end

            ST_INS_WALK:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg + IDX_W'(1);
                if (pts_reg < rd_pts)
                begin
                    // larger entry moves up one slot
                    ram_wdata = ram_rdata;
                    if (ptr_reg == '0)
                    begin
                        state_next = ST_INS_LAST;
                    end
                    else
                    begin
                        ptr_next  = ptr_reg - IDX_W'(1);
                        ram_raddr = ptr_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    ram_wdata  = {tag_reg, pts_reg};
                    state_next = ST_DONE;
                end
            end

            ST_INS_LAST:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = {tag_reg, pts_reg};
                state_next = ST_DONE;
            end

            ST_EXT:
            begin
                if (ptr_reg == '0)
                begin
                    res_otag_next = OUT_TAG_W'(ram_rdata[PTS_W +: TAG_W]);
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ptr_reg - IDX_W'(1);
                    ram_wdata = ram_rdata;
                end
                if (ptr_reg == IDX_W'(1))
                begin
                    head_next = rd_pts;
                end
                // count already holds the new fill, so the last slot is at ptr == count
                if (CNT_W'(ptr_reg) == count_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ptr_next  = ptr_reg + IDX_W'(1);
                    ram_raddr = ptr_reg + IDX_W'(1);
                end
            end

            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_load     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_valid_next = m_valid_reg;
        if (m_load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {{M_PAD_W{1'b0}}, next_pts, FILL_W'(count_reg),
                            res_otag_reg, res_opts_reg};
            m_user_next  = {res_ovalid_reg, res_status_reg};
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        head_reg       <= head_next;
        pts_reg        <= pts_next;
        tag_reg        <= tag_next;
        res_status_reg <= res_status_next;
        res_ovalid_reg <= res_ovalid_next;
        res_opts_reg   <= res_opts_next;
        res_otag_reg   <= res_otag_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

>>> rtl/core/frb_checker.sv
// Port-level checks for the frame reorder buffer, bound to the top level.
// Depends on frb_pkg and frame_reorder_buffer.
`default_nettype none

module frb_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [frb_pkg::M_DATA_W-1:0]  m_tdata,
    input wire logic [frb_pkg::M_USER_W-1:0]  m_tuser
);

    import frb_pkg::*;

    logic [FILL_W-1:0]       fill;
    logic [STATUS_W-1:0]     status;
    logic                    ovalid;
    logic [PTS_W-1:0]        nxt;

    assign fill   = m_tdata[M_FILL_LSB +: FILL_W];
    assign status = m_tuser[M_STATUS_LSB +: STATUS_W];
    assign ovalid = m_tuser[M_OVALID_BIT];
    assign nxt    = m_tdata[M_NEXT_LSB +: PTS_W];

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> fill <= FILL_W'(DEPTH))
        else $error("fill count above depth");

    a_empty_next: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && fill == '0 |-> nxt == PTS_MAX)
        else $error("empty buffer must report max next timestamp");

    a_extract_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ovalid |-> status == STATUS_OK && fill < FILL_W'(DEPTH))
        else $error("extracted entry with error status or full count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status == STATUS_FULL |-> fill == FILL_W'(DEPTH) && !ovalid)
        else $error("full status without a full buffer");

endmodule

bind frame_reorder_buffer frb_checker u_frb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
